// File: rtl/triangle_setpoint_generator_defines.svh
// ----------------------------------------------------------------------------
// Triangle setpoint generator assertion macros
// Concurrent check helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SETPOINT_GENERATOR_DEFINES_SVH
`define TRIANGLE_SETPOINT_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define TSG_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tsg: same-cycle check failed");
`define TSG_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tsg: next-cycle check failed");
`else
`define TSG_ASSERT_SAME(lbl, ck, rstn, ante, cons)
`define TSG_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif

`endif

// File: rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// Triangle setpoint generator package
// Widths, request codes, register map and payload types.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int FULL_SPAN_DEF = 4095;

  localparam int KIND_W     = 2;
  localparam int START_W    = 16;
  localparam int SETPOINT_W = 12;
  localparam int BOUND_W    = 12;
  localparam int STEP_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int SUM_W      = 17;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISARM = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ADVANCE_PERIOD = 2'd3;

  localparam logic [BOUND_W-1:0]  MIN_LEVEL_RST      = 12'd0;
  localparam logic [BOUND_W-1:0]  MAX_LEVEL_RST      = 12'd4095;
  localparam logic [STEP_W-1:0]   STEP_SIZE_RST      = 16'd32;
  localparam logic [PERIOD_W-1:0] ADVANCE_PERIOD_RST = 16'd5000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start_value;
  } tsg_in_t;

  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint;
    logic                  running;
  } tsg_out_t;

  typedef struct packed {
    logic [BOUND_W-1:0]  min_level;
    logic [BOUND_W-1:0]  max_level;
    logic [STEP_W-1:0]   step_size;
    logic [PERIOD_W-1:0] advance_period;
  } tsg_cfg_t;

endpackage

// File: rtl/tsg_regs.sv
// ----------------------------------------------------------------------------
// Triangle setpoint generator register file
// APB-style write and read access to the four configuration registers.
// ----------------------------------------------------------------------------
module tsg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsg_pkg::PADDR_W-1:0] paddr,
  input  logic [tsg_pkg::PDATA_W-1:0] pwdata,
  output logic [tsg_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output tsg_pkg::tsg_cfg_t           cfg
);

  tsg_pkg::tsg_cfg_t                   cfg_r;
  tsg_pkg::tsg_cfg_t                   cfg_nxt;
  logic                                wr_en;
  logic [tsg_pkg::REG_IDX_W-1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[tsg_pkg::PADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        tsg_pkg::REG_MIN_LEVEL:      cfg_nxt.min_level      = pwdata[tsg_pkg::BOUND_W-1:0];
        tsg_pkg::REG_MAX_LEVEL:      cfg_nxt.max_level      = pwdata[tsg_pkg::BOUND_W-1:0];
        tsg_pkg::REG_STEP_SIZE:      cfg_nxt.step_size      = pwdata[tsg_pkg::STEP_W-1:0];
        tsg_pkg::REG_ADVANCE_PERIOD: cfg_nxt.advance_period = pwdata[tsg_pkg::PERIOD_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_level      <= tsg_pkg::MIN_LEVEL_RST;
      cfg_r.max_level      <= tsg_pkg::MAX_LEVEL_RST;
      cfg_r.step_size      <= tsg_pkg::STEP_SIZE_RST;
      cfg_r.advance_period <= tsg_pkg::ADVANCE_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsg_pkg::REG_MIN_LEVEL:      prdata = tsg_pkg::PDATA_W'(cfg_r.min_level);
      tsg_pkg::REG_MAX_LEVEL:      prdata = tsg_pkg::PDATA_W'(cfg_r.max_level);
      tsg_pkg::REG_STEP_SIZE:      prdata = tsg_pkg::PDATA_W'(cfg_r.step_size);
      tsg_pkg::REG_ADVANCE_PERIOD: prdata = tsg_pkg::PDATA_W'(cfg_r.advance_period);
      default:                     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/triangle_setpoint_generator.sv
// ----------------------------------------------------------------------------
// Triangle setpoint generator
// Pipeline: an accepted request enters the input register, its result the result register.
// Throughput: one request per cycle when not stalled; level/tick update is adds and compares.
// Reset: synchronous; level to half span, rising, disarmed, tick count and registers
// to their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
`include "triangle_setpoint_generator_defines.svh"

module triangle_setpoint_generator #(
  parameter int FULL_SPAN = tsg_pkg::FULL_SPAN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tsg_pkg::tsg_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tsg_pkg::tsg_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsg_pkg::PADDR_W-1:0] paddr,
  input  logic [tsg_pkg::PDATA_W-1:0] pwdata,
  output logic [tsg_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int SPAN_W  = $clog2(FULL_SPAN + 1);
  localparam int LEVEL_W = (SPAN_W > tsg_pkg::SETPOINT_W) ? SPAN_W : tsg_pkg::SETPOINT_W;
  localparam int SUM_W   = tsg_pkg::SUM_W;

  tsg_pkg::tsg_cfg_t                  cfg;

  logic                               s1_valid_r;
  logic                               s1_valid_nxt;
  tsg_pkg::tsg_in_t                   s1_data_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  tsg_pkg::tsg_out_t                  out_data_r;
  tsg_pkg::tsg_out_t                  out_data_nxt;

  logic [LEVEL_W-1:0]                 level_r;
  logic [LEVEL_W-1:0]                 level_nxt;
  logic [tsg_pkg::PERIOD_W-1:0]       tick_r;
  logic [tsg_pkg::PERIOD_W-1:0]       tick_nxt;
  logic                               rising_r;
  logic                               rising_nxt;
  logic                               enabled_r;
  logic                               enabled_nxt;

  logic                               out_free;
  logic                               adv;
  logic                               in_acc;
  logic [tsg_pkg::BOUND_W-1:0]        lo;
  logic [tsg_pkg::BOUND_W-1:0]        hi;
  logic [tsg_pkg::STEP_W-1:0]         st;
  logic [tsg_pkg::PERIOD_W-1:0]       per;
  logic [LEVEL_W-1:0]                 start_clamp;
  logic [tsg_pkg::PERIOD_W-1:0]       tick_inc;
  logic [SUM_W-1:0]                   lvl_x;
  logic [SUM_W-1:0]                   up_sum;
  logic [SUM_W-1:0]                   lo_sum;
  logic [SUM_W-1:0]                   lo_x;
  logic [SUM_W-1:0]                   hi_x;
  logic [LEVEL_W-1:0]                 step_level;
  logic                               step_rising;

  tsg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_comb begin
    if (cfg.min_level > cfg.max_level) begin
      lo = cfg.max_level;
      hi = cfg.min_level;
    end else begin
      lo = cfg.min_level;
      hi = cfg.max_level;
    end
  end

  assign st  = (cfg.step_size == '0) ? tsg_pkg::STEP_W'(1) : cfg.step_size;
  assign per = (cfg.advance_period == '0) ? tsg_pkg::PERIOD_W'(1) : cfg.advance_period;

  assign start_clamp = (s1_data_r.start_value > tsg_pkg::START_W'(FULL_SPAN))
                       ? LEVEL_W'(FULL_SPAN) : LEVEL_W'(s1_data_r.start_value);

  assign tick_inc = tick_r + tsg_pkg::PERIOD_W'(1);

  assign lvl_x  = SUM_W'(level_r);
  assign lo_x   = SUM_W'(lo);
  assign hi_x   = SUM_W'(hi);
  assign up_sum = lvl_x + SUM_W'(st);
  assign lo_sum = lo_x + SUM_W'(st);

  always_comb begin
    if (rising_r) begin
      if (up_sum >= hi_x) begin
        step_level  = LEVEL_W'(hi);
        step_rising = 1'b0;
      end else begin
        step_level  = LEVEL_W'(up_sum);
        step_rising = 1'b1;
      end
    end else begin
      if (lvl_x <= lo_sum) begin
        step_level  = LEVEL_W'(lo);
        step_rising = 1'b1;
      end else begin
        step_level  = LEVEL_W'(lvl_x - SUM_W'(st));
        step_rising = 1'b0;
      end
    end
  end

  always_comb begin
    level_nxt   = level_r;
    tick_nxt    = tick_r;
    rising_nxt  = rising_r;
    enabled_nxt = enabled_r;
    if (adv) begin
      unique case (s1_data_r.kind)
        tsg_pkg::KIND_ARM: begin
          level_nxt   = start_clamp;
          tick_nxt    = '0;
          enabled_nxt = 1'b1;
          priority if (SUM_W'(start_clamp) <= lo_x) begin
            rising_nxt = 1'b1;
          end else if (SUM_W'(start_clamp) >= hi_x) begin
            rising_nxt = 1'b0;
          end else begin
            rising_nxt = 1'b1;
          end
        end
        tsg_pkg::KIND_DISARM: begin
          enabled_nxt = 1'b0;
        end
        tsg_pkg::KIND_TICK: begin
          if (enabled_r) begin
            if (tick_inc >= per) begin
              tick_nxt   = '0;
              level_nxt  = step_level;
              rising_nxt = step_rising;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        default: begin
          level_nxt = level_r;
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (adv) begin
      out_data_nxt.setpoint = level_nxt[tsg_pkg::SETPOINT_W-1:0];
      out_data_nxt.running  = enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= LEVEL_W'(FULL_SPAN / 2);
      tick_r      <= '0;
      rising_r    <= 1'b1;
      enabled_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      tick_r      <= tick_nxt;
      rising_r    <= rising_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSG_ASSERT_NEXT(a_state_hold, clk, rst_n, !adv,
    $stable(level_r) && $stable(tick_r) && $stable(rising_r) && $stable(enabled_r))
  `TSG_ASSERT_NEXT(a_arm_clamped, clk, rst_n, adv && (s1_data_r.kind == tsg_pkg::KIND_ARM),
    enabled_r && (tick_r == '0) && (level_r <= LEVEL_W'(FULL_SPAN)))
  `TSG_ASSERT_NEXT(a_disarm_stops, clk, rst_n,
    adv && (s1_data_r.kind == tsg_pkg::KIND_DISARM), !enabled_r && !out_data_r.running)
  `TSG_ASSERT_SAME(a_stall_when_full, clk, rst_n, s1_valid_r && out_valid_r && out_stall,
    in_stall && !adv)

endmodule
